// File: rtl/i2c_smt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2c_smt_pkg;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_SUPPLY = 2'd2;
  localparam logic [1:0] CMD_STOP   = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_ADDR_NACK = 2'd1;
  localparam logic [1:0] ERR_DATA_NACK = 2'd2;
  localparam logic [1:0] ERR_NO_STOP   = 2'd3;

  localparam logic [1:0] REG_LOW_TICKS   = 2'd0;
  localparam logic [1:0] REG_HIGH_TICKS  = 2'd1;
  localparam logic [1:0] REG_FAST_MODE   = 2'd2;
  localparam logic [1:0] REG_VERIFY_STOP = 2'd3;

  localparam logic [15:0] LOW_TICKS_RESET  = 16'd50;
  localparam logic [15:0] HIGH_TICKS_RESET = 16'd40;
  localparam logic [7:0]  READ_FILL        = 8'hFF;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic [7:0] byte_count;
    logic       scl_in;
    logic       sda_in;
  } request_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       want_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [1:0] error_code;
  } result_t;

  typedef struct packed {
    logic       start;
    logic       supply;
    logic       stop;
    logic [7:0] data_byte;
    logic [7:0] byte_count;
    logic       scl_in;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic [15:0] low_ticks;
    logic [15:0] high_ticks;
    logic        fast_mode;
    logic        verify_stop;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/i2c_smt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module i2c_smt_front import i2c_smt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire request_t request,
  output logic          tick_valid,
  input  wire logic     take,
  output tick_t         tick
);

  tick_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  tick_t      classified;

  always_comb begin
    classified.start      = (request.command == CMD_START);
    classified.supply     = (request.command == CMD_SUPPLY);
    classified.stop       = (request.command == CMD_STOP);
    classified.data_byte  = request.data_byte;
    classified.byte_count = request.byte_count;
    classified.scl_in     = request.scl_in;
    classified.sda_in     = request.sda_in;
  end

  assign full       = (count == 2'd2);
  assign accept     = push && !full;
  assign tick_valid = (count != 2'd0);
  assign tick       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({accept, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2c_smt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module i2c_smt_back import i2c_smt_pkg::*; #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  tick_valid,
  output logic       take,
  input  wire tick_t tick,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HELD, PH_SRISE, PH_SFREE, PH_SHOLD, PH_BLOW,
    PH_BRISE, PH_BHIGH, PH_WANT, PH_PRISE, PH_PHIGH, PH_PFREE
  } phase_t;

  phase_t                 phase, phase_next;
  logic [3:0]             bit_index, bit_index_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic [7:0]             bytes_left, bytes_left_next;
  logic [TIMER_WIDTH-1:0] tick_timer, tick_timer_next;
  logic                   in_address_byte, in_address_byte_next;
  logic                   is_write, is_write_next;
  logic [1:0]             error_store, error_store_next;

  logic [TIMER_WIDTH+15:0] low_ext, high_ext;
  logic [TIMER_WIDTH-1:0]  low_arm, high_arm, free_arm;
  logic                    expired;
  logic [7:0]              shifted;
  logic                    drive_bit;
  result_t                 step;

  result_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       retire;

  // Timer loads keep the low bits of a register; a load of zero counts as one.
  assign low_ext  = {{TIMER_WIDTH{1'b0}}, cfg.low_ticks};
  assign high_ext = {{TIMER_WIDTH{1'b0}}, cfg.high_ticks};
  assign low_arm  = (low_ext[TIMER_WIDTH-1:0] == '0) ? TIMER_WIDTH'(1)
                                                     : low_ext[TIMER_WIDTH-1:0];
  assign high_arm = (high_ext[TIMER_WIDTH-1:0] == '0) ? TIMER_WIDTH'(1)
                                                      : high_ext[TIMER_WIDTH-1:0];
  assign free_arm = cfg.fast_mode ? high_arm : low_arm;
  assign expired  = (tick_timer <= TIMER_WIDTH'(1));
  assign shifted  = {shift_byte[6:0], tick.sda_in};

  assign take   = tick_valid && (count != 2'd2);
  assign retire = pop && !empty;
  assign empty  = (count == 2'd0);
  assign result = q[rd_ptr];

  always_comb begin
    phase_next           = phase;
    bit_index_next       = bit_index;
    shift_byte_next      = shift_byte;
    bytes_left_next      = bytes_left;
    tick_timer_next      = tick_timer;
    in_address_byte_next = in_address_byte;
    is_write_next        = is_write;
    error_store_next     = error_store;
    step                 = '0;

    if (tick.start && (phase == PH_IDLE || phase == PH_HELD)) begin
      is_write_next        = ~tick.data_byte[0];
      in_address_byte_next = 1'b1;
      shift_byte_next      = tick.data_byte;
      bytes_left_next      = (tick.byte_count == 8'd0) ? 8'd1 : tick.byte_count;
      bit_index_next       = 4'd0;
      phase_next           = PH_SRISE;
    end else if (tick.supply && phase == PH_WANT) begin
      shift_byte_next = tick.data_byte;
      bit_index_next  = 4'd0;
      tick_timer_next = low_arm;
      phase_next      = PH_BLOW;
    end else if (tick.stop && (phase == PH_IDLE || phase == PH_HELD || phase == PH_WANT)) begin
      phase_next = PH_PRISE;
    end else begin
      case (phase)
        PH_SRISE: begin
          if (tick.scl_in) begin
            tick_timer_next = free_arm;
            phase_next      = PH_SFREE;
          end
        end
        PH_SFREE, PH_SHOLD, PH_PHIGH: begin
          if (!expired) begin
            tick_timer_next = tick_timer - TIMER_WIDTH'(1);
          end else if (phase == PH_SFREE) begin
            tick_timer_next = high_arm;
            phase_next      = PH_SHOLD;
          end else if (phase == PH_SHOLD) begin
            tick_timer_next = low_arm;
            phase_next      = PH_BLOW;
          end else begin
            tick_timer_next = low_arm;
            phase_next      = PH_PFREE;
          end
        end
        PH_BLOW: begin
          if (!expired) begin
            tick_timer_next = tick_timer - TIMER_WIDTH'(1);
          end else begin
            phase_next = PH_BRISE;
          end
        end
        PH_BRISE, PH_PRISE: begin
          if (tick.scl_in) begin
            tick_timer_next = high_arm;
            phase_next      = (phase == PH_BRISE) ? PH_BHIGH : PH_PHIGH;
          end
        end
        PH_BHIGH: begin
          if (!expired) begin
            tick_timer_next = tick_timer - TIMER_WIDTH'(1);
          end else if (bit_index < 4'd8) begin
            shift_byte_next = shifted;
            bit_index_next  = bit_index + 4'd1;
            if (bit_index == 4'd7 && !is_write && !in_address_byte) begin
              step.read_valid = 1'b1;
              step.read_byte  = shifted;
            end
            tick_timer_next = low_arm;
            phase_next      = PH_BLOW;
          end else if ((is_write || in_address_byte) && tick.sda_in) begin
            error_store_next = in_address_byte ? ERR_ADDR_NACK : ERR_DATA_NACK;
            phase_next       = PH_HELD;
          end else begin
            in_address_byte_next = 1'b0;
            bytes_left_next      = bytes_left - 8'd1;
            bit_index_next       = 4'd0;
            if (bytes_left == 8'd1) begin
              step.done_res = 1'b1;
              phase_next    = PH_HELD;
            end else if (is_write) begin
              phase_next = PH_WANT;
            end else begin
              shift_byte_next = READ_FILL;
              tick_timer_next = low_arm;
              phase_next      = PH_BLOW;
            end
          end
        end
        PH_PFREE: begin
          if (!expired) begin
            tick_timer_next = tick_timer - TIMER_WIDTH'(1);
          end else begin
            if (cfg.verify_stop && !(tick.scl_in && tick.sda_in)) begin
              error_store_next = ERR_NO_STOP;
            end else begin
              step.done_res = 1'b1;
            end
            phase_next = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end

    if (bit_index_next < 4'd8) begin
      drive_bit = ~shift_byte_next[7];
    end else if (is_write_next || in_address_byte_next) begin
      drive_bit = 1'b0;
    end else begin
      drive_bit = (bytes_left_next > 8'd1);
    end

    case (phase_next)
      PH_HELD, PH_WANT: begin
        step.scl_low = 1'b1;
        step.sda_low = 1'b0;
      end
      PH_SHOLD, PH_PRISE, PH_PHIGH: begin
        step.scl_low = 1'b0;
        step.sda_low = 1'b1;
      end
      PH_BLOW: begin
        step.scl_low = 1'b1;
        step.sda_low = drive_bit;
      end
      PH_BRISE, PH_BHIGH: begin
        step.scl_low = 1'b0;
        step.sda_low = drive_bit;
      end
      default: begin
        step.scl_low = 1'b0;
        step.sda_low = 1'b0;
      end
    endcase

    step.busy_res   = (phase_next != PH_IDLE) && (phase_next != PH_HELD);
    step.want_byte  = (phase_next == PH_WANT);
    step.error_code = error_store_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_index       <= 4'd0;
      shift_byte      <= READ_FILL;
      bytes_left      <= 8'd0;
      tick_timer      <= '0;
      in_address_byte <= 1'b0;
      is_write        <= 1'b0;
      error_store     <= ERR_NONE;
    end else if (take) begin
      phase           <= phase_next;
      bit_index       <= bit_index_next;
      shift_byte      <= shift_byte_next;
      bytes_left      <= bytes_left_next;
      tick_timer      <= tick_timer_next;
      in_address_byte <= in_address_byte_next;
      is_write        <= is_write_next;
      error_store     <= error_store_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q[wr_ptr] <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr <= ~wr_ptr;
      end
      if (retire) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({take, retire})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/i2c_single_master_transaction.sv
// Single-master I2C bit engine driven one timing tick per request beat.
// Each request carries a command (tick, start, supply byte, stop), a data
// byte, a byte count and the sampled SCL and SDA levels. Every request beat
// gives exactly one result beat: the line drive for the next tick and the
// status of this tick (busy, byte wanted, byte read, done, sticky error).
// Requests enter through push/full, results leave through empty/pop.
// A request beat lands in a two-entry front queue, the bit engine takes one
// beat per cycle while the result queue has room and writes its result into
// a two-entry result queue. A request is registered in the front queue, its
// result in the result queue, and then empty falls so it can be popped.
// The sustained rate is one beat per cycle while results keep being popped.
// When the receiver stops popping, the result queue fills, the engine
// pauses, the front queue fills and full rises; nothing is lost.
// Synchronous reset empties both queues, returns the engine to idle with
// both lines released and loads the register defaults.
// Registers (APB, 32-bit words): 0x0 low_ticks, 0x4 high_ticks,
// 0x8 fast_mode, 0xC verify_stop. Write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module i2c_single_master_transaction import i2c_smt_pkg::*; #(
  parameter int TIMER_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire request_t    request,
  output logic             empty,
  input  wire logic        pop,
  output result_t          result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  logic       tick_valid;
  logic       take;
  tick_t      tick;
  logic       cfg_write;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_ticks   <= LOW_TICKS_RESET;
      cfg.high_ticks  <= HIGH_TICKS_RESET;
      cfg.fast_mode   <= 1'b0;
      cfg.verify_stop <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_LOW_TICKS:   cfg.low_ticks   <= pwdata[15:0];
        REG_HIGH_TICKS:  cfg.high_ticks  <= pwdata[15:0];
        REG_FAST_MODE:   cfg.fast_mode   <= pwdata[0];
        REG_VERIFY_STOP: cfg.verify_stop <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_LOW_TICKS:   prdata = {16'd0, cfg.low_ticks};
      REG_HIGH_TICKS:  prdata = {16'd0, cfg.high_ticks};
      REG_FAST_MODE:   prdata = {31'd0, cfg.fast_mode};
      REG_VERIFY_STOP: prdata = {31'd0, cfg.verify_stop};
      default:         prdata = 32'd0;
    endcase
  end

  i2c_smt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .request    (request),
    .tick_valid (tick_valid),
    .take       (take),
    .tick       (tick)
  );

  i2c_smt_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .take       (take),
    .tick       (tick),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

`default_nettype wire

// File: rtl/i2c_smt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module i2c_smt_checker import i2c_smt_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    empty,
  input wire logic    pop,
  input wire result_t result
);

  // A reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result beat changed");

  // A finished transaction or stop leaves the engine not busy.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.done_res) |-> !result.busy_res)
    else $error("done with engine still busy");

  // A received byte is reported as the next bit's low phase begins.
  a_read_low: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.read_valid) |-> (result.scl_low && result.busy_res))
    else $error("read byte outside a clock low phase");

  a_want_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.want_byte) |-> (result.busy_res && result.scl_low && !result.sda_low))
    else $error("byte wait without SCL held low");

endmodule

bind i2c_single_master_transaction i2c_smt_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire

// File: tb/i2c_smt_tb_pkg.sv
`timescale 1ns / 1ps

package i2c_smt_tb_pkg;
  import i2c_smt_pkg::*;

  typedef enum logic [3:0] {
    ENG_IDLE, ENG_HELD, START_RISE, START_FREE, START_HOLD, BIT_LOW, BIT_RISE, BIT_HIGH,
    WANT_BYTE, STOP_RISE, STOP_HIGH, STOP_FREE
  } engine_phase_t;

  class line_drive_tracker;
    logic [15:0]   low_ticks;
    logic [15:0]   high_ticks;
    logic          fast_mode;
    logic          verify_stop;
    engine_phase_t ph;
    logic [3:0]    bit_idx;
    logic [7:0]    shreg;
    logic [7:0]    bytes_left;
    logic [15:0]   timer;
    logic          addr_byte;
    logic          writing;
    logic [1:0]    err;
    logic          drive_scl;
    logic          drive_sda;
    result_t       pending_drive[$];
    int            failures;
    int            beats_seen;

    function new();
      low_ticks   = LOW_TICKS_RESET;
      high_ticks  = HIGH_TICKS_RESET;
      fast_mode   = 1'b0;
      verify_stop = 1'b0;
      ph          = ENG_IDLE;
      bit_idx     = '0;
      shreg       = READ_FILL;
      bytes_left  = '0;
      timer       = '0;
      addr_byte   = 1'b0;
      writing     = 1'b0;
      err         = ERR_NONE;
      drive_scl   = 1'b0;
      drive_sda   = 1'b0;
      failures    = 0;
      beats_seen  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_LOW_TICKS:   low_ticks = value[15:0];
        REG_HIGH_TICKS:  high_ticks = value[15:0];
        REG_FAST_MODE:   fast_mode = value[0];
        REG_VERIFY_STOP: verify_stop = value[0];
        default: ;
      endcase
    endfunction

    function void load_timer(logic [15:0] ticks);
      timer = (ticks == 16'd0) ? 16'd1 : ticks;
    endfunction

    function bit timer_done();
      if (timer <= 16'd1) return 1'b1;
      timer = timer - 16'd1;
      return 1'b0;
    endfunction

    function logic bit_level();
      if (bit_idx < 4'd8) return ~shreg[7];
      if (writing || addr_byte) return 1'b0;
      return bytes_left > 8'd1;
    endfunction

    function void note_request(request_t r);
      result_t e;
      e = '0;
      if (r.command == CMD_START && (ph == ENG_IDLE || ph == ENG_HELD)) begin
        writing = ~r.data_byte[0];
        addr_byte = 1'b1;
        shreg = r.data_byte;
        bytes_left = (r.byte_count == 8'd0) ? 8'd1 : r.byte_count;
        bit_idx = '0;
        ph = START_RISE;
      end else if (r.command == CMD_SUPPLY && ph == WANT_BYTE) begin
        shreg = r.data_byte;
        bit_idx = '0;
        load_timer(low_ticks);
        ph = BIT_LOW;
      end else if (r.command == CMD_STOP && ph inside {ENG_IDLE, ENG_HELD, WANT_BYTE}) begin
        ph = STOP_RISE;
      end else begin
        case (ph)
          START_RISE: if (r.scl_in) begin
            load_timer(fast_mode ? high_ticks : low_ticks);
            ph = START_FREE;
          end
          START_FREE: if (timer_done()) begin
            load_timer(high_ticks);
            ph = START_HOLD;
          end
          START_HOLD: if (timer_done()) begin
            load_timer(low_ticks);
            ph = BIT_LOW;
          end
          BIT_LOW: if (timer_done()) ph = BIT_RISE;
          BIT_RISE: if (r.scl_in) begin
            load_timer(high_ticks);
            ph = BIT_HIGH;
          end
          BIT_HIGH: if (timer_done()) begin
            if (bit_idx < 4'd8) begin
              shreg = {shreg[6:0], r.sda_in};
              bit_idx = bit_idx + 4'd1;
              if (bit_idx == 4'd8 && !writing && !addr_byte) begin
                e.read_valid = 1'b1;
                e.read_byte = shreg;
              end
              load_timer(low_ticks);
              ph = BIT_LOW;
            end else if ((writing || addr_byte) && r.sda_in) begin
              err = addr_byte ? ERR_ADDR_NACK : ERR_DATA_NACK;
              ph = ENG_HELD;
            end else begin
              addr_byte = 1'b0;
              bytes_left = bytes_left - 8'd1;
              bit_idx = '0;
              if (bytes_left == 8'd0) begin
                e.done_res = 1'b1;
                ph = ENG_HELD;
              end else if (writing) begin
                ph = WANT_BYTE;
              end else begin
                shreg = READ_FILL;
                load_timer(low_ticks);
                ph = BIT_LOW;
              end
            end
          end
          STOP_RISE: if (r.scl_in) begin
            load_timer(high_ticks);
            ph = STOP_HIGH;
          end
          STOP_HIGH: if (timer_done()) begin
            load_timer(low_ticks);
            ph = STOP_FREE;
          end
          STOP_FREE: if (timer_done()) begin
            if (verify_stop && !(r.scl_in && r.sda_in)) err = ERR_NO_STOP;
            else e.done_res = 1'b1;
            ph = ENG_IDLE;
          end
          default: ;
        endcase
      end

      case (ph)
        ENG_HELD, WANT_BYTE: begin
          e.scl_low = 1'b1;
          e.sda_low = 1'b0;
        end
        START_HOLD, STOP_RISE, STOP_HIGH: begin
          e.scl_low = 1'b0;
          e.sda_low = 1'b1;
        end
        BIT_LOW: begin
          e.scl_low = 1'b1;
          e.sda_low = bit_level();
        end
        BIT_RISE, BIT_HIGH: begin
          e.scl_low = 1'b0;
          e.sda_low = bit_level();
        end
        default: begin
          e.scl_low = 1'b0;
          e.sda_low = 1'b0;
        end
      endcase
      e.busy_res = !(ph inside {ENG_IDLE, ENG_HELD});
      e.want_byte = (ph == WANT_BYTE);
      e.error_code = err;
      drive_scl = e.scl_low;
      drive_sda = e.sda_low;
      pending_drive.push_back(e);
    endfunction

    function void flag(string what, result_t want, result_t got);
      failures++;
      if (failures <= 10) begin
        $display("beat %0d %s: expected scl=%b sda=%b busy=%b want=%b rv=%b rb=%02h done=%b err=%0d",
                 beats_seen, what,
                 want.scl_low, want.sda_low, want.busy_res, want.want_byte, want.read_valid,
                 want.read_byte, want.done_res, want.error_code);
        $display("  got scl=%b sda=%b busy=%b want=%b rv=%b rb=%02h done=%b err=%0d",
                 got.scl_low, got.sda_low, got.busy_res, got.want_byte, got.read_valid,
                 got.read_byte, got.done_res, got.error_code);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit bad;
      beats_seen++;
      if (pending_drive.size() == 0) begin
        flag("result beat with nothing expected", '0, got);
        return;
      end
      want = pending_drive.pop_front();
      bad = (got.scl_low !== want.scl_low) || (got.sda_low !== want.sda_low) ||
            (got.busy_res !== want.busy_res) || (got.want_byte !== want.want_byte) ||
            (got.read_valid !== want.read_valid) || (got.read_byte !== want.read_byte) ||
            (got.done_res !== want.done_res) || (got.error_code !== want.error_code);
      if (bad) flag("mismatch", want, got);
    endfunction

    function void close_out();
      if (pending_drive.size() != 0) begin
        failures += pending_drive.size();
        $display("%0d expected result beats never arrived", pending_drive.size());
      end
    endfunction
  endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import i2c_smt_pkg::*;
  import i2c_smt_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  request_t    request = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  line_drive_tracker sb;

  bit chaos = 1'b0;
  bit quiet = 1'b0;
  int addr_nack_odds = 0;
  int data_nack_odds = 0;
  int stop_glitch_odds = 0;
  int hold_requests = 0;
  int ticks_sent = 0;

  i2c_single_master_transaction u_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit chance(input int odds);
    return odds != 0 && $urandom_range(1, odds) == 1;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // The slave side of the bus follows the predicted drive, stretches the clock now and
  // then, ACKs or NACKs address and write beats by the odds, returns random read bits.
  function automatic request_t line_levels(input logic [1:0] cmd, input logic [7:0] data,
                                           input logic [7:0] count);
    request_t r;
    logic     slave_low;
    r.command = cmd;
    r.data_byte = data;
    r.byte_count = count;
    slave_low = 1'b0;
    if (chaos) begin
      r.scl_in = 1'($urandom_range(0, 1));
      r.sda_in = 1'($urandom_range(0, 1));
      return r;
    end
    r.scl_in = !sb.drive_scl;
    if (r.scl_in && sb.ph inside {START_RISE, BIT_RISE, STOP_RISE} && chance(4))
      r.scl_in = 1'b0;
    if (sb.ph inside {BIT_LOW, BIT_RISE, BIT_HIGH}) begin
      if (sb.bit_idx == 4'd8 && (sb.writing || sb.addr_byte))
        slave_low = sb.addr_byte ? !chance(addr_nack_odds) : !chance(data_nack_odds);
      else if (sb.bit_idx < 4'd8 && !sb.writing && !sb.addr_byte)
        slave_low = 1'($urandom_range(0, 1));
    end
    r.sda_in = !(sb.drive_sda || slave_low);
    if (sb.ph == STOP_FREE && chance(stop_glitch_odds)) r.sda_in = 1'b0;
    return r;
  endfunction

  task automatic drive_tick(input logic [1:0] cmd, input logic [7:0] data,
                            input logic [7:0] count);
    request_t r;
    if (!quiet && chance(8)) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    r = line_levels(cmd, data, count);
    push <= 1'b1;
    request <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(r);
    ticks_sent++;
  endtask

  task automatic plain_tick();
    drive_tick(CMD_TICK, rand_byte(), rand_byte());
  endtask

  task automatic settle_engine();
    while (!(sb.ph inside {ENG_IDLE, ENG_HELD, WANT_BYTE})) begin
      if (chance(16))
        drive_tick(2'($urandom_range(CMD_START, CMD_STOP)), rand_byte(), rand_byte());
      else
        plain_tick();
    end
  endtask

  task automatic bring_to_rest();
    settle_engine();
    if (sb.ph == WANT_BYTE) begin
      drive_tick(CMD_STOP, rand_byte(), rand_byte());
      settle_engine();
    end
  endtask

  task automatic run_transfer(input logic [7:0] addr, input logic [7:0] count,
                              input int stop_odds);
    drive_tick(CMD_START, addr, count);
    settle_engine();
    while (sb.ph == WANT_BYTE) begin
      repeat ($urandom_range(0, 2)) plain_tick();
      if (chance(stop_odds))
        drive_tick(CMD_STOP, rand_byte(), rand_byte());
      else
        drive_tick(CMD_SUPPLY, rand_byte(), rand_byte());
      settle_engine();
    end
  endtask

  task automatic noise_burst(input int n);
    chaos = 1'b1;
    repeat (n)
      drive_tick(2'($urandom_range(CMD_TICK, CMD_STOP)), rand_byte(), rand_byte());
    chaos = 1'b0;
    bring_to_rest();
  endtask

  function automatic logic [7:0] pick_count();
    if (chance(10)) return 8'd0;
    if (chance(12)) return 8'($urandom_range(5, 12));
    return 8'($urandom_range(1, 4));
  endfunction

  task automatic random_phase(input int n);
    int goal;
    goal = ticks_sent + n;
    while (ticks_sent < goal) begin
      if (chance(12)) noise_burst($urandom_range(2, 10));
      else run_transfer(rand_byte(), pick_count(), 5);
      if (chance(3)) begin
        drive_tick(CMD_STOP, rand_byte(), rand_byte());
        settle_engine();
      end
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (sb.pending_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] lo, input logic [15:0] hi,
                                input logic fast, input logic verify);
    drain_results();
    write_reg(REG_LOW_TICKS, {16'd0, lo});
    write_reg(REG_HIGH_TICKS, {16'd0, hi});
    write_reg(REG_FAST_MODE, {31'd0, fast});
    write_reg(REG_VERIFY_STOP, {31'd0, verify});
  endtask

  initial begin : result_sink
    int stall;
    int hold_count;
    int holds_done;
    stall = 0;
    hold_count = 0;
    holds_done = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (pop && !empty) sb.check_result(result);
      if (holds_done != hold_requests) begin
        hold_count = 60;
        holds_done++;
      end
      if (hold_count > 0) begin
        pop <= 1'b0;
        hold_count--;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (!quiet && chance(10)) begin
        pop <= 1'b0;
        stall = $urandom_range(0, 3);
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int wait_cycles;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apply_settings(16'd1, 16'd2, 1'b0, 1'b1);
    plain_tick();
    drive_tick(CMD_SUPPLY, 8'hFF, 8'hFF);
    drive_tick(CMD_STOP, 8'h00, 8'h00);
    settle_engine();
    drive_tick(CMD_START, 8'h00, 8'h00);
    drive_tick(CMD_START, 8'hFF, 8'hFF);
    drive_tick(CMD_SUPPLY, 8'h00, 8'h01);
    drive_tick(CMD_STOP, 8'hFF, 8'h00);
    settle_engine();
    run_transfer(8'hA1, 8'd2, 0);
    run_transfer(8'h5A, 8'd3, 1);
    addr_nack_odds = 1;
    run_transfer(8'h42, 8'd255, 0);
    addr_nack_odds = 0;
    data_nack_odds = 1;
    run_transfer(8'h42, 8'd2, 0);
    data_nack_odds = 0;
    stop_glitch_odds = 1;
    drive_tick(CMD_STOP, 8'h00, 8'h00);
    settle_engine();
    stop_glitch_odds = 0;
    run_transfer(8'hFE, 8'd2, 0);

    apply_settings(16'd1, 16'd1, 1'b1, 1'b1);
    run_transfer(8'h81, 8'd3, 0);
    addr_nack_odds = 10;
    data_nack_odds = 12;
    stop_glitch_odds = 6;
    random_phase(30);

    apply_settings(16'd3, 16'd2, 1'b0, 1'b0);
    hold_requests++;
    random_phase(30);

    // A zero tick count behaves as a single tick.
    apply_settings(16'd0, 16'd0, 1'b1, 1'b0);
    random_phase(20);

    apply_settings(16'($urandom_range(2, 6)), 16'($urandom_range(1, 5)), 1'b1, 1'b1);
    random_phase(20);

    apply_settings(16'd40, 16'd24, 1'b1, 1'b1);
    drive_tick(CMD_STOP, rand_byte(), rand_byte());
    settle_engine();

    apply_settings(16'd2, 16'd1, 1'b0, 1'b1);
    quiet = 1'b1;
    random_phase(30);

    push <= 1'b0;
    wait_cycles = 0;
    while (sb.pending_drive.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
